// ===== rtl/nfdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the nibble frame deframer.
// Depends on nothing; used by every module under rtl.
package nfdc_pkg;

	// Default window depth in bytes
	localparam int MAX_FRAME_LEN_DEF = 64;

	// Configuration port geometry
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 8;

	// Register indexes
	localparam logic [CFG_IW-1:0] REG_HEAD_BYTE    = 3'd0;
	localparam logic [CFG_IW-1:0] REG_TAIL_BYTE    = 3'd1;
	localparam logic [CFG_IW-1:0] REG_FRAME_LENGTH = 3'd2;
	localparam logic [CFG_IW-1:0] REG_SUM_START    = 3'd3;
	localparam logic [CFG_IW-1:0] REG_SUM_POSITION = 3'd4;
	localparam logic [CFG_IW-1:0] REG_SUM_INITIAL  = 3'd5;

	// Register reset values
	localparam logic [7:0] RST_HEAD_BYTE    = 8'h82;
	localparam logic [7:0] RST_TAIL_BYTE    = 8'h83;
	localparam logic [6:0] RST_FRAME_LENGTH = 7'd22;
	localparam logic [5:0] RST_SUM_START    = 6'd1;
	localparam logic [5:0] RST_SUM_POSITION = 6'd19;
	localparam logic [7:0] RST_SUM_INITIAL  = 8'h00;

	typedef struct packed {
		logic [7:0] head_byte;
		logic [7:0] tail_byte;
		logic [6:0] frame_length;
		logic [5:0] sum_start;
		logic [5:0] sum_position;
		logic [7:0] sum_initial;
	} cfg_t;

endpackage

// ===== rtl/nfdc_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register bank for the nibble frame deframer.
// Depends on nfdc_pkg for register indexes, reset values and cfg_t.
module nfdc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [nfdc_pkg::CFG_IW-1:0] cfg_addr,
	input  logic [nfdc_pkg::CFG_DW-1:0] cfg_wdata,
	output nfdc_pkg::cfg_t              cfg
);
	import nfdc_pkg::*;

	cfg_t cfg_q;

	// Write one register per transfer; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_byte    <= RST_HEAD_BYTE;
			cfg_q.tail_byte    <= RST_TAIL_BYTE;
			cfg_q.frame_length <= RST_FRAME_LENGTH;
			cfg_q.sum_start    <= RST_SUM_START;
			cfg_q.sum_position <= RST_SUM_POSITION;
			cfg_q.sum_initial  <= RST_SUM_INITIAL;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_HEAD_BYTE:    cfg_q.head_byte    <= cfg_wdata;
				REG_TAIL_BYTE:    cfg_q.tail_byte    <= cfg_wdata;
				REG_FRAME_LENGTH: cfg_q.frame_length <= cfg_wdata[6:0];
				REG_SUM_START:    cfg_q.sum_start    <= cfg_wdata[5:0];
				REG_SUM_POSITION: cfg_q.sum_position <= cfg_wdata[5:0];
				REG_SUM_INITIAL:  cfg_q.sum_initial  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/nfdc_check.sv =====
`timescale 1ns / 1ps
// Byte window shift line, frame checks and frame-found decision.
// Depends on nfdc_pkg; feeds the frame store in nfdc_emit.
module nfdc_check #(
	parameter int MAX_FRAME_LEN = nfdc_pkg::MAX_FRAME_LEN_DEF,
	parameter int NW            = $clog2(MAX_FRAME_LEN + 1),
	parameter int AW            = $clog2(2 * MAX_FRAME_LEN + 2)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  nfdc_pkg::cfg_t cfg,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [7:0]     s_tdata,
	input  logic           emit_busy,
	output logic           wr_en,
	output logic [AW-1:0]  wr_addr,
	output logic [7:0]     wr_data,
	output logic           frm_go,
	output logic [AW-1:0]  frm_end,
	output logic [NW-1:0]  frm_len
);
	import nfdc_pkg::*;

	localparam int SW = $clog2(2 * MAX_FRAME_LEN + 64);
	localparam int NG = (MAX_FRAME_LEN + 7) / 8;
	localparam int NT = NG * 8;
	localparam logic [SW-1:0] BASE  = SW'(MAX_FRAME_LEN);
	localparam logic [NW-1:0] MAX_N = NW'(MAX_FRAME_LEN);

	logic [7:0]    win_q [MAX_FRAME_LEN];
	logic [NW-1:0] fill_q;
	logic [NW-1:0] skip_q;
	logic [NW-1:0] eff_n;
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] wa_s1;
	logic [AW-1:0] wa_s2;
	logic          v1_q;
	logic          v2_q;
	logic          accept;
	logic          stall2;
	logic          proc;
	logic          good;
	logic [SW-1:0] n_ext;
	logic [SW-1:0] lo_bound;
	logic [SW-1:0] hi_bound;
	logic [7:0]    pair [NT];
	logic [NT-1:0] add_en;
	logic [NT-1:0] head_hit;
	logic [NT-1:0] chk_hit;
	logic [7:0]    grp [NG];
	logic [7:0]    grp_s2 [NG];
	logic [7:0]    chk_val;
	logic [7:0]    chk_s2;
	logic [7:0]    total;
	logic          head_ok;
	logic          tail_ok;
	logic          head_ok_s2;
	logic          tail_ok_s2;
	logic          fill_ok_s2;

	// Clamp the frame length to the supported range
	always_comb begin
		if (cfg.frame_length < 7'd3) begin
			eff_n = NW'(3);
		end else if (int'(cfg.frame_length) > MAX_FRAME_LEN) begin
			eff_n = MAX_N;
		end else begin
			eff_n = NW'(cfg.frame_length);
		end
	end

	// Handshake: hold the input only while a candidate waits for the emitter
	assign stall2   = v2_q && (skip_q == '0) && emit_busy;
	assign s_tready = !stall2;
	assign accept   = s_tvalid && s_tready;
	assign proc     = v2_q && !stall2;

	// Every received byte also goes to the frame store
	assign wr_en   = accept;
	assign wr_addr = wptr_q;
	assign wr_data = s_tdata;

	// Shift the new byte into the window, newest at the top
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_FRAME_LEN - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[MAX_FRAME_LEN - 1] <= s_tdata;
		end
	end

	// Frame offset of tap g is g + n - MAX; bounds are compared in that frame
	assign n_ext    = SW'(eff_n);
	assign lo_bound = BASE + SW'(cfg.sum_start);
	assign hi_bound = BASE + SW'(cfg.sum_position);

	for (genvar g = 0; g < NT; g++) begin : g_tap
		if (g < MAX_FRAME_LEN) begin : g_live
			logic [3:0]    lo_nib;
			logic [SW-1:0] t_off;
			if (g + 1 < MAX_FRAME_LEN) begin : g_next
				assign lo_nib = win_q[g + 1][3:0];
			end else begin : g_top
				assign lo_nib = 4'h0;
			end
			assign t_off       = SW'(g) + n_ext;
			assign pair[g]     = {win_q[g][3:0], lo_nib};
			assign add_en[g]   = (t_off >= lo_bound) && (t_off < hi_bound) &&
				(t_off[0] == lo_bound[0]);
			assign head_hit[g] = (t_off == BASE) && (win_q[g] == cfg.head_byte);
			assign chk_hit[g]  = (t_off == hi_bound);
		end else begin : g_pad
			assign pair[g]     = 8'h00;
			assign add_en[g]   = 1'b0;
			assign head_hit[g] = 1'b0;
			assign chk_hit[g]  = 1'b0;
		end
	end

	// Partial sums of the selected nibble pairs, eight taps per group
	always_comb begin
		for (int gi = 0; gi < NG; gi++) begin
			grp[gi] = 8'h00;
			for (int k = 0; k < 8; k++) begin
				if (add_en[gi * 8 + k]) begin
					grp[gi] = grp[gi] + pair[gi * 8 + k];
				end
			end
		end
	end

	// Pick the checksum pair; at most one tap matches
	always_comb begin
		chk_val = 8'h00;
		for (int g = 0; g < NT; g++) begin
			chk_val = chk_val | (chk_hit[g] ? pair[g] : 8'h00);
		end
	end

	assign head_ok = |head_hit;
	assign tail_ok = (win_q[MAX_FRAME_LEN - 1] == cfg.tail_byte);

	// Check stage register
	always_ff @(posedge clk) begin
		if (!stall2) begin
			grp_s2     <= grp;
			chk_s2     <= chk_val;
			head_ok_s2 <= head_ok;
			tail_ok_s2 <= tail_ok;
			fill_ok_s2 <= (fill_q >= eff_n);
			wa_s2      <= wa_s1;
		end
		if (accept) begin
			wa_s1 <= wptr_q;
		end
	end

	// Finish the checksum and decide
	always_comb begin
		total = cfg.sum_initial;
		for (int gi = 0; gi < NG; gi++) begin
			total = total + grp_s2[gi];
		end
	end

	assign good    = fill_ok_s2 && head_ok_s2 && tail_ok_s2 && (total == chk_s2);
	assign frm_go  = proc && (skip_q == '0) && good;
	assign frm_end = wa_s2;
	assign frm_len = eff_n;

	// Control: valid flags, fill level, write pointer, suppression count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			fill_q <= '0;
			wptr_q <= '0;
			skip_q <= '0;
		end else begin
			if (!stall2) begin
				v1_q <= accept;
				v2_q <= v1_q;
			end
			if (accept) begin
				wptr_q <= wptr_q + AW'(1);
				if (fill_q != MAX_N) begin
					fill_q <= fill_q + NW'(1);
				end
			end
			if (proc) begin
				if (skip_q != '0) begin
					skip_q <= skip_q - NW'(1);
				end else if (good) begin
					skip_q <= eff_n - NW'(1);
				end
			end
		end
	end

`ifndef SYNTH
	a_go_sets_skip: assert property (@(posedge clk) disable iff (!arst_n)
		frm_go |=> (skip_q != '0))
		else $error("frame accepted without suppressing the following windows");

	a_stall_keeps_item: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && !s_tready) |=> v2_q)
		else $error("candidate window dropped while held");
`endif

endmodule

// ===== rtl/nfdc_emit.sv =====
`timescale 1ns / 1ps
// Frame store and read-out: received bytes are written in a ring,
// accepted frames are read back one byte per transfer. Depends on nfdc_pkg.
module nfdc_emit #(
	parameter int MAX_FRAME_LEN = nfdc_pkg::MAX_FRAME_LEN_DEF,
	parameter int NW            = $clog2(MAX_FRAME_LEN + 1),
	parameter int AW            = $clog2(2 * MAX_FRAME_LEN + 2)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          frm_go,
	input  logic [AW-1:0] frm_end,
	input  logic [NW-1:0] frm_len,
	output logic          busy,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,
	output logic          m_tlast
);
	import nfdc_pkg::*;

	localparam int DEPTH = 1 << AW;

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] raddr_q;
	logic [NW-1:0] rem_q;
	logic          ov_q;
	logic [7:0]    od_q;
	logic          olast_q;
	logic          issue;

	// Byte ring write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign busy  = (rem_q != '0);
	assign issue = busy && (!ov_q || m_tready);

	// Registered read straight into the output register
	always_ff @(posedge clk) begin
		if (issue) begin
			od_q    <= mem[raddr_q];
			olast_q <= (rem_q == NW'(1));
		end
	end

	// Advance the read pointer; load it at the first byte of a new frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raddr_q <= '0;
			rem_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (frm_go) begin
				raddr_q <= frm_end - AW'(frm_len) + AW'(1);
				rem_q   <= frm_len;
			end else if (issue) begin
				raddr_q <= raddr_q + AW'(1);
				rem_q   <= rem_q - NW'(1);
			end
			if (issue) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;
	assign m_tlast  = olast_q;

`ifndef SYNTH
	a_go_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		frm_go |-> !busy)
		else $error("new frame started while read-out in progress");

	a_go_starts: assert property (@(posedge clk) disable iff (!arst_n)
		frm_go |=> busy)
		else $error("accepted frame did not start read-out");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && (rem_q == NW'(1))) |=> !busy)
		else $error("read-out continued past the last byte");
`endif

endmodule

// ===== rtl/nibble_frame_deframer_checksum_top.sv =====
`timescale 1ns / 1ps
// Received bytes enter on s_axis at up to one transfer per cycle and shift a window of the
// last MAX_FRAME_LEN bytes. Each window is checked in two register stages (head, tail and the
// nibble-pair checksum as eight-tap partial sums, then the final sum and compare); a good frame
// is read from a byte ring of 2^AW entries and leaves on m_axis one byte per transfer, tlast on
// its final byte; the tail byte passes the window, check, read pointer and output registers
// before the first byte leaves. Input keeps flowing at one byte per cycle while a frame is read
// out; it is held only when a new candidate window reaches the decision before the previous
// frame's read-out has finished, so the ring's single read port sets the rate: one frame byte
// per cycle while m_axis is ready. Depends on nfdc_pkg, nfdc_cfg, nfdc_check and nfdc_emit.
module nibble_frame_deframer_checksum_top #(
	parameter int MAX_FRAME_LEN = nfdc_pkg::MAX_FRAME_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [nfdc_pkg::CFG_IW-1:0] cfg_addr,
	input  logic [nfdc_pkg::CFG_DW-1:0] cfg_wdata,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,  // [7:0] frame_byte
	output logic                        m_axis_tlast
);
	import nfdc_pkg::*;

	localparam int NW = $clog2(MAX_FRAME_LEN + 1);
	localparam int AW = $clog2(2 * MAX_FRAME_LEN + 2);

	cfg_t          cfg;
	logic          emit_busy;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          frm_go;
	logic [AW-1:0] frm_end;
	logic [NW-1:0] frm_len;

	// Register bank
	nfdc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Window and frame checks
	nfdc_check #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN),
		.NW            (NW),
		.AW            (AW)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.s_tdata   (s_axis_tdata),
		.emit_busy (emit_busy),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.frm_go    (frm_go),
		.frm_end   (frm_end),
		.frm_len   (frm_len)
	);

	// Frame store and read-out
	nfdc_emit #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN),
		.NW            (NW),
		.AW            (AW)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.frm_go   (frm_go),
		.frm_end  (frm_end),
		.frm_len  (frm_len),
		.busy     (emit_busy),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tlast  (m_axis_tlast)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the nibble frame deframer: streams received bytes in, predicts
// every emitted frame byte from a shadow copy of the window and settings, checks m_axis.
// Depends on nfdc_pkg and nibble_frame_deframer_checksum_top.
module testbench;
	import nfdc_pkg::*;

	localparam int WIN_DEPTH    = MAX_FRAME_LEN_DEF;
	localparam int QUIET_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 200000;

	// Indexes outside the register map; writes to them must change nothing
	localparam logic [CFG_IW-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IW-1:0] REG_SPARE_B = 3'd7;

	typedef struct {
		logic [7:0] frame_byte;
		logic       last_of_frame;
	} frame_byte_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = '0;   // [7:0] rx_byte
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;        // [7:0] frame_byte
	logic              m_axis_tlast;

	// Shadow of the block: settings, byte window, fill level, windows left to skip
	cfg_t        shadow_cfg;
	logic [7:0]  win [0:WIN_DEPTH-1];
	int          win_fill = 0;
	int          skip_left = 0;
	logic [7:0]  cand [0:WIN_DEPTH-1];
	frame_byte_t pending_frame_bytes [$];

	int mismatch_count = 0;
	int rx_sent = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_len = 0;
	bit hold_req = 1'b0;
	bit hold_ack = 1'b0;
	int hold_left = 0;

	nibble_frame_deframer_checksum_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Abort the run when the cycle count reaches CYCLE_LIMIT
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		shadow_cfg.head_byte    = RST_HEAD_BYTE;
		shadow_cfg.tail_byte    = RST_TAIL_BYTE;
		shadow_cfg.frame_length = RST_FRAME_LENGTH;
		shadow_cfg.sum_start    = RST_SUM_START;
		shadow_cfg.sum_position = RST_SUM_POSITION;
		shadow_cfg.sum_initial  = RST_SUM_INITIAL;
		for (int k = 0; k < WIN_DEPTH; k++) begin
			win[k]  = 8'h00;
			cand[k] = 8'h00;
		end
	end

	// Frame length as the block uses it: clamp to 3 .. window depth
	function automatic int eff_len();
		int n;
		n = shadow_cfg.frame_length;
		if (n < 3) n = 3;
		if (n > WIN_DEPTH) n = WIN_DEPTH;
		return n;
	endfunction

	// Candidate byte at frame offset k; reads as zero past the frame
	function automatic logic [7:0] cand_at(input int k, input int n);
		if (k >= n) return 8'h00;
		return cand[k];
	endfunction

	function automatic logic [7:0] pair_at(input int p, input int n);
		logic [7:0] hi, lo;
		hi = cand_at(p, n);
		lo = cand_at(p + 1, n);
		return {hi[3:0], lo[3:0]};
	endfunction

	function automatic logic [7:0] nibble_checksum(input int n);
		logic [7:0] s;
		int p;
		s = shadow_cfg.sum_initial;
		for (p = shadow_cfg.sum_start; p < shadow_cfg.sum_position; p += 2)
			s = s + pair_at(p, n);
		return s;
	endfunction

	function automatic bit cand_is_frame(input int n);
		return cand[0] == shadow_cfg.head_byte && cand[n-1] == shadow_cfg.tail_byte &&
			nibble_checksum(n) == pair_at(shadow_cfg.sum_position, n);
	endfunction

	// Shift one received byte into the shadow window and queue any frame it completes
	function automatic void absorb_rx_byte(input logic [7:0] b);
		int n, k;
		n = eff_len();
		for (k = 0; k < WIN_DEPTH - 1; k++)
			win[k] = win[k+1];
		win[WIN_DEPTH-1] = b;
		if (win_fill < WIN_DEPTH) win_fill++;
		if (skip_left > 0) begin
			skip_left--;
			return;
		end
		if (win_fill < n) return;
		for (k = 0; k < n; k++)
			cand[k] = win[WIN_DEPTH-n+k];
		if (!cand_is_frame(n)) return;
		for (k = 0; k < n; k++)
			pending_frame_bytes.push_back('{cand[k], k == n - 1});
		skip_left = n - 1;
	endfunction

	// Fill cand with a frame under the current settings: random body, then search the
	// checksum pair nibbles until the check passes (where the pair bytes are free to change)
	function automatic void build_frame(input int n);
		int k, h, sp;
		logic [7:0] s;
		sp = shadow_cfg.sum_position;
		for (k = 0; k < n; k++)
			cand[k] = 8'($urandom_range(0, 255));
		cand[0]   = shadow_cfg.head_byte;
		cand[n-1] = shadow_cfg.tail_byte;
		for (h = 0; h < 16; h++) begin
			if (sp >= 1 && sp <= n - 2) cand[sp][3:0] = 4'(h);
			s = nibble_checksum(n);
			if (sp + 1 >= 1 && sp + 1 <= n - 2) cand[sp+1][3:0] = s[3:0];
			if (cand_is_frame(n)) break;
		end
	endfunction

	// Register write: the block samples it at the next rising edge
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_HEAD_BYTE:    shadow_cfg.head_byte    = val;
			REG_TAIL_BYTE:    shadow_cfg.tail_byte    = val;
			REG_FRAME_LENGTH: shadow_cfg.frame_length = val[6:0];
			REG_SUM_START:    shadow_cfg.sum_start    = val[5:0];
			REG_SUM_POSITION: shadow_cfg.sum_position = val[5:0];
			REG_SUM_INITIAL:  shadow_cfg.sum_initial  = val;
			default: ;
		endcase
	endtask

	// Write every register, then a stray write to an unmapped index that must be ignored
	task automatic load_config(input logic [7:0] head, input logic [7:0] tail,
			input logic [7:0] len, input logic [7:0] start, input logic [7:0] pos,
			input logic [7:0] init);
		write_reg(REG_HEAD_BYTE, head);
		write_reg(REG_TAIL_BYTE, tail);
		write_reg(REG_FRAME_LENGTH, len);
		write_reg(REG_SUM_START, start);
		write_reg(REG_SUM_POSITION, pos);
		write_reg(REG_SUM_INITIAL, init);
		write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
			8'($urandom_range(0, 255)));
		cfg_we <= 1'b0;
	endtask

	// Offer one byte on s_axis, with random idle cycles first; hold until the transfer
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		absorb_rx_byte(b);
		rx_sent++;
	endtask

	// Send one frame for the current settings; a damaged one has one byte corrupted
	task automatic send_frame(input bit damage);
		logic [7:0] frame_copy [0:WIN_DEPTH-1];
		int n, k;
		n = eff_len();
		build_frame(n);
		for (k = 0; k < n; k++)
			frame_copy[k] = cand[k];
		if (damage) begin
			k = $urandom_range(0, n - 1);
			frame_copy[k] = frame_copy[k] ^ 8'($urandom_range(1, 255));
		end
		for (k = 0; k < n; k++)
			send_byte(frame_copy[k]);
	endtask

	// Drop tvalid, drain every expected frame byte, then let the pipeline go quiet
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_frame_bytes.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic randomise_config();
		int n, m, start, pos;
		n = $urandom_range(0, 99);
		if (n < 75) n = $urandom_range(3, 12);
		else if (n < 85) n = $urandom_range(0, 2);
		else if (n < 93) n = $urandom_range(13, 40);
		else n = $urandom_range(65, 127);
		m = (n < 3) ? 3 : ((n > WIN_DEPTH) ? WIN_DEPTH : n);
		start = ($urandom_range(0, 3) != 0) ? $urandom_range(0, m - 1) : $urandom_range(0, 63);
		pos   = ($urandom_range(0, 3) != 0) ? $urandom_range(1, m - 1) : $urandom_range(0, 63);
		load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			{1'($urandom_range(0, 1)), 7'(n)},
			{2'($urandom_range(0, 3)), 6'(start)},
			{2'($urandom_range(0, 3)), 6'(pos)},
			8'($urandom_range(0, 255)));
	endtask

	// Check each m_axis transfer against the oldest expected frame byte; pick tready
	always @(posedge clk) begin
		frame_byte_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_frame_bytes.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected frame byte: expected none, got %02h last %0b",
					$time, m_axis_tdata, m_axis_tlast);
			end else begin
				want = pending_frame_bytes.pop_front();
				if (m_axis_tdata !== want.frame_byte) begin
					mismatch_count++;
					$display("%0t: frame_byte mismatch: expected %02h, got %02h",
						$time, want.frame_byte, m_axis_tdata);
				end
				if (m_axis_tlast !== want.last_of_frame) begin
					mismatch_count++;
					$display("%0t: last_of_frame mismatch: expected %0b, got %0b",
						$time, want.last_of_frame, m_axis_tlast);
				end
			end
		end
		if (hold_req != hold_ack) begin
			hold_ack  = hold_req;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Shortest frames straight after reset: no check until the window holds a frame,
	// no summed pairs, and a checksum pair that runs off the end of the frame
	task automatic test_unfilled_window_min_length();
		logic [7:0] rx_seq [0:7];
		rx_seq = '{8'hFF, 8'hFF, 8'h00, 8'h5A, 8'hFF, 8'h00, 8'hA5, 8'hFF};
		load_config(8'h00, 8'hFF, 8'h00, 8'd5, 8'd2, 8'hF0);
		foreach (rx_seq[k])
			send_byte(rx_seq[k]);
		settle();
	endtask

	// Checksum over nibble pairs, both pair alignments, good and damaged frames
	task automatic test_checksum_pairs();
		load_config(8'h55, 8'hAA, 8'd6, 8'd1, 8'd3, 8'h3C);
		send_frame(1'b0);
		send_frame(1'b1);
		settle();
		load_config(8'h82, 8'h83, 8'd6, 8'd0, 8'd3, 8'hFF);
		send_frame(1'b0);
		settle();
	endtask

	// Longest frames: over-range length clamps to the window, checksum at the far end
	task automatic test_longest_frames();
		logic [7:0] tail;
		load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'hFF, 8'd0,
			8'd60, 8'($urandom_range(0, 255)));
		send_frame(1'b0);
		settle();
		tail = 8'($urandom_range(0, 255));
		load_config(8'($urandom_range(0, 255)), tail, 8'd64, 8'hFF, 8'd62,
			{4'($urandom_range(0, 15)), tail[3:0]});
		send_frame(1'b0);
		settle();
	endtask

	// Mostly well-formed frames with random content, some damaged frames and loose bytes
	task automatic test_random_traffic();
		int mode, ph, first, r;
		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 86;
				end
				1: begin
					send_idle_pct = 86;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (ph = 0; ph < 2; ph++) begin
				settle();
				randomise_config();
				first = rx_sent;
				while (rx_sent - first < 22) begin
					r = $urandom_range(0, 99);
					if (r < 70) begin
						send_frame(1'b0);
					end else if (r < 85) begin
						send_frame(1'b1);
					end else begin
						repeat ($urandom_range(1, 4))
							send_byte(($urandom_range(0, 3) == 0) ? shadow_cfg.head_byte :
								8'($urandom_range(0, 255)));
					end
				end
			end
		end
		settle();
	endtask

	// Hold m_axis off for a long stretch while frames keep arriving back to back
	task automatic test_output_backpressure();
		int f;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd8, 8'd1,
			8'd5, 8'($urandom_range(0, 255)));
		hold_len <= 400;
		hold_req <= ~hold_req;
		for (f = 0; f < 6; f++)
			send_frame(1'b0);
		settle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unfilled_window_min_length();
		test_checksum_pairs();
		test_longest_frames();
		test_random_traffic();
		test_output_backpressure();
		settle();
		if (mismatch_count == 0 && pending_frame_bytes.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/nfdc_pkg.sv
rtl/nfdc_cfg.sv
rtl/nfdc_check.sv
rtl/nfdc_emit.sv
rtl/nibble_frame_deframer_checksum_top.sv
dv/testbench.sv
